FILE: sv/tbeq_pkg.sv
`default_nettype none

package tbeq_pkg;

    // Default values for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int STATE_FRAC_BITS_DEF = 24;

    // Fixed datapath widths
    localparam int STATE_W = 48;              // pole and history words
    localparam int OPA_W   = 52;              // signed operand of the Q16 multiply
    localparam int HALF_W  = OPA_W / 2;       // operand split point
    localparam int COEF_W  = 18;
    localparam int GAIN_W  = 19;
    localparam int MULB_W  = GAIN_W;          // unsigned operand of the Q16 multiply
    localparam int RES_W   = OPA_W + MULB_W - 16;  // Q16 product after the shift
    localparam int ACC_W   = RES_W + 2;       // sum of three bands
    localparam int MAG_W   = ACC_W + 1;       // magnitude of the sum
    localparam int OUT_W   = 21;
    localparam int Q16_SHIFT = 16;

    // Configuration port
    localparam int CFG_W     = GAIN_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_COEF  = 3'd0,
        CFG_HIGH_COEF = 3'd1,
        CFG_LOW_GAIN  = 3'd2,
        CFG_MID_GAIN  = 3'd3,
        CFG_HIGH_GAIN = 3'd4
    } cfg_idx_t;

    localparam logic [COEF_W-1:0] LOW_COEF_RST  = COEF_W'(7546);
    localparam logic [COEF_W-1:0] HIGH_COEF_RST = COEF_W'(42147);
    localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(65536);

    // Output saturation limits
    localparam logic [MAG_W-1:0] OUT_MAX_MAG = MAG_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] OUT_MIN_MAG = MAG_W'(64'd1 << (OUT_W - 1));
    localparam logic [OUT_W-1:0] OUT_MAX_VAL = OUT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [OUT_W-1:0] OUT_MIN_VAL = OUT_W'(64'd1 << (OUT_W - 1));

endpackage

`default_nettype wire

FILE: sv/tbeq_mul.sv
`default_nettype none

// Shared Q16 multiply: res = (a * b + 2^15) >> 16, floor shift, exact.
// The signed operand is split in two halves, one partial product per cycle.
// a and b must hold from start until done.
module tbeq_mul
    import tbeq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [OPA_W-1:0] a,
    input  wire logic        [MULB_W-1:0] b,
    output logic                         done,
    output logic signed [RES_W-1:0]      res
);

    localparam int MOP_W  = HALF_W + 1;
    localparam int PROD_W = MOP_W + MULB_W + 1;
    localparam int FULL_W = PROD_W + HALF_W;

    typedef enum logic [1:0] {
        M_IDLE,
        M_HI,
        M_SUM
    } mstate_t;

    mstate_t                    state_reg;
    logic                       done_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [RES_W-1:0]    res_reg;

    logic signed [MOP_W-1:0]    mop;
    logic signed [MULB_W:0]     mb;
    logic signed [PROD_W-1:0]   prod;
    logic signed [FULL_W-1:0]   full;

    // Pick the low half (unsigned) or the high half (signed)
    always_comb
    begin
        if (state_reg == M_IDLE)
        begin
            mop = $signed({1'b0, a[HALF_W-1:0]});
        end
        else
        begin
            mop = $signed({a[OPA_W-1], a[OPA_W-1:HALF_W]});
        end
        mb   = $signed({1'b0, b});
        prod = mop * mb;
    end

    // Recombine the partial products and round
    assign full = (FULL_W'(prod_reg) <<< HALF_W) + FULL_W'(acc_reg)
                + (FULL_W'(1) <<< (Q16_SHIFT - 1));

    // Sequence the two partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == M_SUM);
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= M_HI;
                    end
                end
                M_HI:
                begin
                    state_reg <= M_SUM;
                end
                M_SUM:
                begin
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                prod_reg <= prod;
            end
            M_HI:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= prod;
            end
            M_SUM:
            begin
                res_reg <= full[RES_W+Q16_SHIFT-1:Q16_SHIFT];
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

FILE: sv/three_band_equalizer.sv
`default_nettype none

// Three-band audio equalizer with cascaded one-pole crossovers.
//
// Input channel: in_valid / in_stall / sample_in. A request is taken at a
// rising edge with in_valid high and in_stall low. in_stall is high while a
// sample is being processed, so one sample is in flight at a time.
// Output channel: out_valid / out_stall / sample_out, one result per sample.
// Configuration: cfg_we / cfg_index / cfg_data, write only, while idle.
//
// Datapath: all eleven Q16 products (eight crossover poles, three band gains)
// run through one shared multiplier one after another, followed by a rounding
// step and an emit step; a new request is taken only once the sequencer has
// left the emit step and is idle again.
// The output register lets the next sample be taken while a result still
// waits; if the receiver stalls with a result pending, the next result holds
// in its final step until the pending one is taken.
// Reset clears all poles and input history and loads the default
// coefficients and unity gains.
module three_band_equalizer
    import tbeq_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int STATE_FRAC_BITS = STATE_FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [OUT_W-1:0]             sample_out,
    input  wire logic                           cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic        [CFG_W-1:0]        cfg_data
);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST     = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_HIGH_BAND = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_LOW_BAND  = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_MID_BAND  = STEP_W'(10);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      start_reg;
    logic                      out_valid_reg;
    logic signed [OUT_W-1:0]   out_data_reg;

    logic [COEF_W-1:0]         low_coef_reg;
    logic [COEF_W-1:0]         high_coef_reg;
    logic [GAIN_W-1:0]         low_gain_reg;
    logic [GAIN_W-1:0]         mid_gain_reg;
    logic [GAIN_W-1:0]         high_gain_reg;

    logic signed [STATE_W-1:0] lp_reg [4];
    logic signed [STATE_W-1:0] hp_reg [4];
    logic signed [STATE_W-1:0] hist_reg [3];

    logic signed [STATE_W-1:0] x_reg;
    logic signed [STATE_W-1:0] prev_reg;
    logic signed [OPA_W-1:0]   op_a_reg;
    logic        [MULB_W-1:0]  op_b_reg;
    logic signed [OPA_W-1:0]   hl_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic        [MAG_W-1:0]   mag_reg;
    logic                      neg_reg;

    logic signed [STATE_W-1:0] x_next;
    logic [1:0]                pole_idx;
    logic                      is_chain;
    logic signed [STATE_W-1:0] pole_rd;
    logic signed [STATE_W-1:0] pole_next;
    logic signed [OPA_W-1:0]   op_a_next;
    logic        [MULB_W-1:0]  op_b_next;
    logic signed [OPA_W-1:0]   hl_next;
    logic signed [MAG_W-1:0]   acc_ext;
    logic        [MAG_W-1:0]   mag_next;
    logic        [MAG_W-1:0]   q;
    logic signed [OUT_W-1:0]   out_next;
    logic                      emit_ok;
    logic                      in_take;
    logic                      mul_done;
    logic signed [RES_W-1:0]   mul_res;

    // Shared Q16 multiplier
    tbeq_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .a     (op_a_reg),
        .b     (op_b_reg),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign in_take  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign emit_ok  = !out_valid_reg || !out_stall;

    // Scale the sample into the state format, wrapping to the state width
    assign x_next = STATE_W'(STATE_W'(sample_in) <<< STATE_FRAC_BITS);

    // Select the pole of the current crossover step
    assign pole_idx  = step_reg[1:0];
    assign is_chain  = (step_reg < STEP_HIGH_BAND);
    assign pole_rd   = step_reg[2] ? hp_reg[pole_idx] : lp_reg[pole_idx];
    assign pole_next = STATE_W'(RES_W'(pole_rd) + mul_res);

    // Build the multiplier operands for the current step
    always_comb
    begin
        hl_next = hl_reg;
        if (is_chain)
        begin
            op_a_next = OPA_W'(prev_reg) - OPA_W'(pole_rd);
            op_b_next = step_reg[2] ? MULB_W'(high_coef_reg) : MULB_W'(low_coef_reg);
        end
        else
        begin
            case (step_reg)
                STEP_HIGH_BAND:
                begin
                    op_a_next = OPA_W'(hist_reg[2]) - OPA_W'(hp_reg[3]);
                    op_b_next = high_gain_reg;
                    hl_next   = op_a_next;
                end
                STEP_LOW_BAND:
                begin
                    op_a_next = OPA_W'(lp_reg[3]);
                    op_b_next = low_gain_reg;
                    hl_next   = hl_reg + OPA_W'(lp_reg[3]);
                end
                default:
                begin
                    op_a_next = OPA_W'(x_reg) - hl_reg;
                    op_b_next = mid_gain_reg;
                end
            endcase
        end
    end

    // Round half away from zero and saturate
    always_comb
    begin
        acc_ext  = MAG_W'(acc_reg);
        mag_next = (acc_reg < 0) ? MAG_W'(-acc_ext) : MAG_W'(acc_ext);
        q        = (mag_reg + (MAG_W'(1) << (STATE_FRAC_BITS - 1))) >> STATE_FRAC_BITS;
        if (neg_reg)
        begin
            out_next = (q >= OUT_MIN_MAG) ? OUT_MIN_VAL : OUT_W'(MAG_W'(0) - q);
        end
        else
        begin
            out_next = (q > OUT_MAX_MAG) ? OUT_MAX_VAL : OUT_W'(q);
        end
    end

    // Sequencer, filter state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_FIRST;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            low_coef_reg  <= LOW_COEF_RST;
            high_coef_reg <= HIGH_COEF_RST;
            low_gain_reg  <= GAIN_RST;
            mid_gain_reg  <= GAIN_RST;
            high_gain_reg <= GAIN_RST;
            for (int i = 0; i < 4; i++)
            begin
                lp_reg[i] <= '0;
                hp_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            start_reg <= (state_reg == S_ISSUE);

            // Raise the result from the emit step, drop it once the receiver takes it
            if (state_reg == S_EMIT && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOW_COEF:  low_coef_reg  <= cfg_data[COEF_W-1:0];
                    CFG_HIGH_COEF: high_coef_reg <= cfg_data[COEF_W-1:0];
                    CFG_LOW_GAIN:  low_gain_reg  <= cfg_data;
                    CFG_MID_GAIN:  mid_gain_reg  <= cfg_data;
                    CFG_HIGH_GAIN: high_gain_reg <= cfg_data;
                    default:       ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        step_reg  <= STEP_FIRST;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (is_chain)
                        begin
                            if (step_reg[2])
                            begin
                                hp_reg[pole_idx] <= pole_next;
                            end
                            else
                            begin
                                lp_reg[pole_idx] <= pole_next;
                            end
                        end
                        if (step_reg == STEP_MID_BAND)
                        begin
                            state_reg <= S_ROUND;
                        end
                        else
                        begin
                            step_reg  <= step_reg + STEP_W'(1);
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ROUND:
                begin
                    hist_reg[2] <= hist_reg[1];
                    hist_reg[1] <= hist_reg[0];
                    hist_reg[0] <= x_reg;
                    state_reg   <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers of the datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    x_reg    <= x_next;
                    prev_reg <= x_next;
                    acc_reg  <= '0;
                end
            end
            S_ISSUE:
            begin
                op_a_reg <= op_a_next;
                op_b_reg <= op_b_next;
                hl_reg   <= hl_next;
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    if (is_chain)
                    begin
                        // Restart the chain input for the high crossover
                        prev_reg <= (pole_idx == 2'd3) ? x_reg : pole_next;
                    end
                    else
                    begin
                        acc_reg <= acc_reg + ACC_W'(mul_res);
                    end
                end
            end
            S_ROUND:
            begin
                neg_reg <= (acc_reg < 0);
                mag_reg <= mag_next;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_data_reg <= out_next;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // The multiplier reports done only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_WAIT))
        else $error("multiplier done outside of wait state");

    // A new result appears only from the emit step
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside of emit step");

    // The step counter never runs past the mid band
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_MID_BAND)
        else $error("step counter out of range");

    // Requests are only taken while the sequencer is idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_ISSUE))
        else $error("request taken while busy");

endmodule

`default_nettype wire
